FILE: sv/common_divisor_count_top_defines.svh
// ----------------------------------------------------------------------------
// Common divisor count - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef COMMON_DIVISOR_COUNT_TOP_DEFINES_SVH
`define COMMON_DIVISOR_COUNT_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define CDC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define CDC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches reset itself
`define CDC_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - package
// Shared types and constants for the front end, request queue and back end.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int VALUE_BITS_DEF = 20;
    localparam int COUNT_BITS     = 10;
    localparam int M_TDATA_BITS   = 16;
    localparam int Q_DEPTH        = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 10'd1023;

    // How the back end has to treat a request
    typedef enum logic [1:0] {
        KIND_GENERAL,
        KIND_ONE_ZERO,
        KIND_BOTH_ZERO
    } cdc_kind_t;

    localparam int KIND_BITS = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } cdc_q_stat_t;

endpackage

FILE: sv/common_divisor_count_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - top level
// Counts the positive integers that divide both operands of each request.
// ----------------------------------------------------------------------------
// One result per request. The back end forms the gcd g by Euclid's rule and
// then tries every i with i*i <= g; each remainder comes from one shared
// bit-serial divider. Requests are worked one at a time; a two-entry
// queue and an input register let up to three more requests wait, and a
// finished count waits in the output register while the next request runs.
// Both operands zero gives 0; counts above 1023 saturate.
module common_divisor_count_top #(
    parameter int VALUE_BITS = cdc_pkg::VALUE_BITS_DEF,
    localparam int S_TDATA_BITS = ((2 * VALUE_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_BITS-1:0]          s_tdata,  // first_value, second_value, pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cdc_pkg::M_TDATA_BITS-1:0] m_tdata   // divisor_count, pad
);

    localparam int ITEM_BITS = 2 * VALUE_BITS + cdc_pkg::KIND_BITS;

    cdc_pkg::cdc_q_stat_t          q_stat;
    logic                          push;
    logic [ITEM_BITS-1:0]          push_data;
    logic                          pop;
    logic [ITEM_BITS-1:0]          pop_data;
    logic                          rem_start;
    logic [VALUE_BITS-1:0]         rem_dividend;
    logic [VALUE_BITS-1:0]         rem_divisor;
    logic                          rem_done;
    logic [VALUE_BITS-1:0]         rem_value;
    logic [cdc_pkg::COUNT_BITS-1:0] out_count;

    cdc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .first_value  (s_tdata[VALUE_BITS-1:0]),
        .second_value (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    cdc_queue #(.WIDTH(ITEM_BITS)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    cdc_rem #(.VALUE_BITS(VALUE_BITS)) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .done      (rem_done),
        .remainder (rem_value)
    );

    cdc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .pop          (pop),
        .pop_data     (pop_data),
        .rem_start    (rem_start),
        .rem_dividend (rem_dividend),
        .rem_divisor  (rem_divisor),
        .rem_done     (rem_done),
        .rem_value    (rem_value),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_count    (out_count)
    );

    assign m_tdata = {{(cdc_pkg::M_TDATA_BITS - cdc_pkg::COUNT_BITS){1'b0}}, out_count};

endmodule

FILE: sv/cdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - front end
// Accepts operand pairs, tags each with its kind and pushes it into the queue.
// ----------------------------------------------------------------------------
module cdc_front #(
    parameter int VALUE_BITS = cdc_pkg::VALUE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [VALUE_BITS-1:0]                 first_value,
    input  logic [VALUE_BITS-1:0]                 second_value,
    input  cdc_pkg::cdc_q_stat_t                  q_stat,
    output logic                                  push,
    output logic [2*VALUE_BITS+cdc_pkg::KIND_BITS-1:0] push_data
);

    logic                   valid_reg;
    logic [VALUE_BITS-1:0]  a_reg;
    logic [VALUE_BITS-1:0]  b_reg;
    cdc_pkg::cdc_kind_t     kind_reg;
    cdc_pkg::cdc_kind_t     kind_next;
    logic                   accept;

    assign push     = valid_reg && !q_stat.full;
    assign in_ready = !valid_reg || !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (first_value == '0 && second_value == '0) begin
            kind_next = cdc_pkg::KIND_BOTH_ZERO;
        end else if (first_value == '0 || second_value == '0) begin
            kind_next = cdc_pkg::KIND_ONE_ZERO;
        end else begin
            kind_next = cdc_pkg::KIND_GENERAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg    <= first_value;
            b_reg    <= second_value;
            kind_reg <= kind_next;
        end
    end

    assign push_data = {kind_reg, b_reg, a_reg};

endmodule

FILE: sv/cdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - request queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cdc_queue #(
    parameter int WIDTH = 2 * cdc_pkg::VALUE_BITS_DEF + cdc_pkg::KIND_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output cdc_pkg::cdc_q_stat_t q_stat
);

    localparam int PTR_BITS = (cdc_pkg::Q_DEPTH > 1) ? $clog2(cdc_pkg::Q_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(cdc_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0]    mem [cdc_pkg::Q_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;

    assign q_stat.full  = (fill_reg == CNT_BITS'(cdc_pkg::Q_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(cdc_pkg::Q_DEPTH - 1)) ? '0
                                                                                : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(cdc_pkg::Q_DEPTH - 1)) ? '0
                                                                                : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/cdc_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module cdc_rem #(
    parameter int VALUE_BITS = cdc_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [VALUE_BITS-1:0]  n_reg;
    logic [VALUE_BITS-1:0]  d_reg;
    logic [VALUE_BITS:0]    r_reg;
    logic [VALUE_BITS:0]    shifted;
    logic [VALUE_BITS:0]    r_next;

    always_comb begin
        shifted = {r_reg[VALUE_BITS-1:0], n_reg[VALUE_BITS-1]};
        if (shifted >= {1'b0, d_reg}) begin
            r_next = shifted - {1'b0, d_reg};
        end else begin
            r_next = shifted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(VALUE_BITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end else if (busy_reg) begin
            n_reg <= {n_reg[VALUE_BITS-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign remainder = r_reg[VALUE_BITS-1:0];

endmodule

FILE: sv/cdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - back end
// Runs Euclid's rule and then trial division on the shared remainder unit,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module cdc_back #(
    parameter int VALUE_BITS = cdc_pkg::VALUE_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  cdc_pkg::cdc_q_stat_t                       q_stat,
    output logic                                       pop,
    input  logic [2*VALUE_BITS+cdc_pkg::KIND_BITS-1:0] pop_data,
    output logic                                       rem_start,
    output logic [VALUE_BITS-1:0]                      rem_dividend,
    output logic [VALUE_BITS-1:0]                      rem_divisor,
    input  logic                                       rem_done,
    input  logic [VALUE_BITS-1:0]                      rem_value,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [cdc_pkg::COUNT_BITS-1:0]             out_count
);

    localparam int IDX_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = VALUE_BITS + 2;
    localparam int CW       = cdc_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUC_START,
        ST_EUC_WAIT,
        ST_TRIAL_CHECK,
        ST_TRIAL_WAIT,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  x_reg, x_next;
    logic [VALUE_BITS-1:0]  y_reg, y_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [SQ_BITS-1:0]     sq_reg, sq_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          out_count_reg, out_count_next;

    logic [VALUE_BITS-1:0]  in_a;
    logic [VALUE_BITS-1:0]  in_b;
    cdc_pkg::cdc_kind_t     in_kind;
    logic                   sq_over;
    logic [CW:0]            cnt_sum;
    logic                   out_free;

    assign in_a    = pop_data[VALUE_BITS-1:0];
    assign in_b    = pop_data[2*VALUE_BITS-1:VALUE_BITS];
    assign in_kind = cdc_pkg::cdc_kind_t'(pop_data[2*VALUE_BITS+:cdc_pkg::KIND_BITS]);

    // x_reg carries the gcd once Euclid's loop is done
    assign sq_over   = sq_reg > {2'b00, x_reg};
    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;
    assign rem_start = (state_reg == ST_EUC_START) || (state_reg == ST_TRIAL_CHECK && !sq_over);
    assign rem_dividend = x_reg;
    assign rem_divisor  = (state_reg == ST_EUC_START) ? y_reg : VALUE_BITS'(idx_reg);

    always_comb begin
        cnt_sum = {1'b0, cnt_reg} + ((sq_reg == {2'b00, x_reg}) ? (CW + 1)'(1) : (CW + 1)'(2));
    end

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        idx_next       = idx_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_count_next = out_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    x_next   = in_a | in_b;
                    y_next   = in_b;
                    idx_next = IDX_BITS'(1);
                    sq_next  = SQ_BITS'(1);
                    cnt_next = '0;
                    unique case (in_kind)
                        cdc_pkg::KIND_GENERAL: begin
                            x_next     = in_a;
                            state_next = ST_EUC_START;
                        end
                        cdc_pkg::KIND_ONE_ZERO: begin
                            state_next = ST_TRIAL_CHECK;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EUC_START: begin
                state_next = ST_EUC_WAIT;
            end
            ST_EUC_WAIT: begin
                if (rem_done) begin
                    x_next = y_reg;
                    y_next = rem_value;
                    state_next = (rem_value == '0) ? ST_TRIAL_CHECK : ST_EUC_START;
                end
            end
            ST_TRIAL_CHECK: begin
                state_next = sq_over ? ST_EMIT : ST_TRIAL_WAIT;
            end
            ST_TRIAL_WAIT: begin
                if (rem_done) begin
                    if (rem_value == '0) begin
                        cnt_next = (cnt_sum > {1'b0, cdc_pkg::COUNT_MAX}) ? cdc_pkg::COUNT_MAX
                                                                          : cnt_sum[CW-1:0];
                    end
                    // (i+1)^2 = i^2 + 2i + 1
                    sq_next    = sq_reg + SQ_BITS'({idx_reg, 1'b1});
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TRIAL_CHECK;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        x_reg         <= x_next;
        y_reg         <= y_next;
        idx_reg       <= idx_next;
        sq_reg        <= sq_next;
        cnt_reg       <= cnt_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

endmodule

FILE: sv/cdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "common_divisor_count_top_defines.svh"

module cdc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cdc_pkg::M_TDATA_BITS-1:0] m_tdata
);

    `CDC_ASSERT_NXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `CDC_ASSERT_RST(a_reset_drops_result, aclk, !aresetn, !m_tvalid, "result valid after reset")
    `CDC_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[cdc_pkg::M_TDATA_BITS-1:cdc_pkg::COUNT_BITS] == '0, "result padding not zero")

endmodule

bind common_divisor_count_top cdc_checker u_cdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Common divisor count - testbench
// Drives operand pairs into the stream input and checks each returned count
// against a local gcd-and-trial-division predictor. Covers zero and full-scale
// operands, squares, primes and long Euclid chains, shaped random pairs, and
// random idling on both channels plus one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VALUE_BITS = cdc_pkg::VALUE_BITS_DEF;
    localparam int S_BITS     = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam logic [VALUE_BITS-1:0] OPERAND_MAX = '1;

    typedef struct {
        logic [VALUE_BITS-1:0]          first_value;
        logic [VALUE_BITS-1:0]          second_value;
        logic [cdc_pkg::COUNT_BITS-1:0] divisor_count;
    } divisor_request_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [S_BITS-1:0]                s_tdata = '0;    // first_value, second_value
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [cdc_pkg::M_TDATA_BITS-1:0] m_tdata;         // divisor_count, pad

    // Expected counts in request order; the indexes wrap with the ring size
    divisor_request_t expected_counts [256];
    logic [7:0]       exp_wr_idx = '0;
    logic [7:0]       exp_rd_idx = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int rx_hold_left = 0;
    int requests_sent = 0;
    int zero_operand_requests = 0;
    int counts_checked = 0;
    int error_count = 0;

    common_divisor_count_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Number of common divisors: gcd by remainders, then divisor pairs up to sqrt
    function automatic logic [cdc_pkg::COUNT_BITS-1:0] common_divisor_total(
        input logic [VALUE_BITS-1:0] a,
        input logic [VALUE_BITS-1:0] b
    );
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] i;
        logic [63:0] total;
        x = 64'(a);
        y = 64'(b);
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        total = 0;
        for (i = 1; i * i <= x; i = i + 1) begin
            if (x % i == 0) begin
                total = total + ((i * i == x) ? 64'd1 : 64'd2);
            end
        end
        if (total > 64'(cdc_pkg::COUNT_MAX)) begin
            total = 64'(cdc_pkg::COUNT_MAX);
        end
        return total[cdc_pkg::COUNT_BITS-1:0];
    endfunction

    // Offer one request; valid stays high after acceptance until the next call
    task automatic send_pair(input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b);
        divisor_request_t req;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        req.first_value   = a;
        req.second_value  = b;
        req.divisor_count = common_divisor_total(a, b);
        expected_counts[exp_wr_idx] = req;
        exp_wr_idx = exp_wr_idx + 8'd1;
        requests_sent++;
        if (a == 0 || b == 0) begin
            zero_operand_requests++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen    <= hold_seq;
            rx_hold_left <= hold_len;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        divisor_request_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_wr_idx == exp_rd_idx) begin
                $display("%0t: unexpected count %0d", $time,
                         m_tdata[cdc_pkg::COUNT_BITS-1:0]);
                error_count++;
            end else begin
                want = expected_counts[exp_rd_idx];
                exp_rd_idx = exp_rd_idx + 8'd1;
                counts_checked++;
                if (m_tdata[cdc_pkg::COUNT_BITS-1:0] !== want.divisor_count) begin
                    $display("%0t: count for (%0d, %0d): expected %0d, got %0d", $time,
                             want.first_value, want.second_value, want.divisor_count,
                             m_tdata[cdc_pkg::COUNT_BITS-1:0]);
                    error_count++;
                end
                if (m_tdata[cdc_pkg::M_TDATA_BITS-1:cdc_pkg::COUNT_BITS] !== '0) begin
                    $display("%0t: pad bits: expected 0, got %0h", $time,
                             m_tdata[cdc_pkg::M_TDATA_BITS-1:cdc_pkg::COUNT_BITS]);
                    error_count++;
                end
            end
        end
    end

    task automatic run_edge_operands();
        send_pair(0, 0);
        send_pair(0, OPERAND_MAX);
        send_pair(OPERAND_MAX, 0);
        send_pair(OPERAND_MAX, OPERAND_MAX);
        send_pair(1, 1);
        send_pair(1, OPERAND_MAX);
        send_pair(0, 1);
        send_pair(1, 0);
        send_pair(4, 6);
        send_pair(36, 36);
        // highly composite and a square at the top of the range
        send_pair(831600, 0);
        send_pair(0, 1046529);
        // largest prime below 2^20: long trial run, count of two
        send_pair(1048573, 0);
        // consecutive Fibonacci numbers: longest Euclid chain
        send_pair(832040, 514229);
        send_pair(524288, OPERAND_MAX);
        send_pair(524288, 786432);
        send_pair(20'hAAAAA, 20'h55555);
        send_pair(20'h55555, 20'hAAAAA);
        send_pair(720720, 360360);
    endtask

    // Mostly pairs built on a chosen common factor, so the gcd varies widely
    task automatic run_random_pairs(input int n);
        int g;
        int sel;
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                g = $urandom_range(4095, 1);
            end else if (sel < 65) begin
                g = $urandom_range(65535, 1);
            end else begin
                g = 0;
            end
            if (g != 0) begin
                a = VALUE_BITS'(g * $urandom_range(int'(OPERAND_MAX) / g));
                b = VALUE_BITS'(g * $urandom_range(int'(OPERAND_MAX) / g));
            end else if (sel < 90) begin
                a = VALUE_BITS'($urandom());
                b = VALUE_BITS'($urandom());
            end else if (sel < 95) begin
                a = VALUE_BITS'($urandom_range(65535));
                b = '0;
                if ($urandom_range(1)) begin
                    b = a;
                    a = '0;
                end
            end else begin
                a = VALUE_BITS'($urandom());
                b = a;
            end
            send_pair(a, b);
        end
    endtask

    // Hold the output off while requests keep coming so the input stalls
    task automatic run_output_stall();
        int g;
        tx_idle_pct = 0;
        hold_len <= 4000;
        hold_seq <= hold_seq + 1;
        repeat (8) begin
            g = $urandom_range(15, 1);
            send_pair(VALUE_BITS'(g * $urandom_range(4000)),
                      VALUE_BITS'(g * $urandom_range(4000)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 38;
        rx_idle_pct <= 48;
        run_edge_operands();
        run_random_pairs(24);

        tx_idle_pct = 48;
        rx_idle_pct <= 38;
        run_random_pairs(24);
        run_output_stall();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_random_pairs(24);
        s_tvalid <= 1'b0;

        while (exp_wr_idx != exp_rd_idx) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("tb_top: %0d requests (%0d with a zero operand), %0d counts checked",
                 requests_sent, zero_operand_requests, counts_checked);
        $display("tb_top: idling on both sides, one 4000-cycle output stall");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/cdc_pkg.sv
sv/cdc_front.sv
sv/cdc_queue.sv
sv/cdc_rem.sv
sv/cdc_back.sv
sv/common_divisor_count_top.sv
sv/cdc_checker.sv
verif/tb_top.sv
